[sv/rid_ie_pkg.sv]
// shared types, constants and helpers for the remote id frame element filter
package rid_ie_pkg;

    // field widths fixed by the interface
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FLEN_W  = 12;
    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned NEXT_W  = 13;
    localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;

    // frame layout
    localparam int unsigned NAN_ADDR_FIRST = 4;
    localparam int unsigned NAN_ADDR_LAST  = 9;
    localparam int unsigned SRC_FIRST      = 10;
    localparam int unsigned SRC_LAST       = 15;
    localparam int unsigned NAN_MIN_LEN    = 16;
    localparam int unsigned IE_START       = 36;
    localparam int unsigned IE_HDR_LEN     = 2;
    localparam int unsigned VENDOR_MIN_LEN = 3;
    localparam int unsigned PAYLOAD_SKIP   = 7;

    // byte offsets inside a vendor element
    localparam int unsigned OUI_REL_0 = 2;
    localparam int unsigned OUI_REL_1 = 3;
    localparam int unsigned OUI_REL_2 = 4;

    // byte codes
    localparam logic [BYTE_W-1:0] BEACON_CODE = 8'h80;
    localparam logic [BYTE_W-1:0] VENDOR_IE   = 8'hdd;
    localparam logic [BYTE_W-1:0] OUI_A_0     = 8'h90;
    localparam logic [BYTE_W-1:0] OUI_A_1     = 8'h3a;
    localparam logic [BYTE_W-1:0] OUI_A_2     = 8'he6;
    localparam logic [BYTE_W-1:0] OUI_B_0     = 8'hfa;
    localparam logic [BYTE_W-1:0] OUI_B_1     = 8'h0b;
    localparam logic [BYTE_W-1:0] OUI_B_2     = 8'hbc;

    // result kinds
    localparam logic KIND_NAN    = 1'b0;
    localparam logic KIND_BEACON = 1'b1;

    // input word
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [FLEN_W-1:0] frame_length;
        logic              is_management;
        logic              last_byte;
    } item_t;

    // result word
    typedef struct packed {
        logic              match_kind;
        logic [ADDR_W-1:0] source_address;
        logic              oui_select;
        logic [FLEN_W-1:0] payload_offset;
        logic [FLEN_W-1:0] payload_length;
    } result_t;

    // nan cluster address 51:6f:9a:01:00:00
    function automatic logic [BYTE_W-1:0] nan_cluster_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            3'd0:    v = 8'h51;
            3'd1:    v = 8'h6f;
            3'd2:    v = 8'h9a;
            3'd3:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[sv/remote_id_frame_ie_filter_core.sv]
// remote id frame element filter top level
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    frame byte, frame length, mgmt flag, last-byte mark
//  m_        out  m_valid/m_ready    kind, source address, oui select, offset, length
//
// one word per cycle while no result waits on a stalled m_ side
// the input register feeds one pass of compare/add logic into the result register
// reset (aresetn low at a clock edge) empties both registers and restarts frame tracking
// a stalled m_ side holds the result; the input register keeps taking words until it fills
module remote_id_frame_ie_filter_core
    import rid_ie_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_frame_byte,
    input  logic [FLEN_W-1:0] s_frame_length,
    input  logic              s_is_management,
    input  logic              s_last_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_match_kind,
    output logic [ADDR_W-1:0] m_source_address,
    output logic              m_oui_select,
    output logic [FLEN_W-1:0] m_payload_offset,
    output logic [FLEN_W-1:0] m_payload_length
);

    item_t   s_item, item;
    result_t res, m_res;
    logic    item_valid, res_valid, advance;

    // input word packing
    assign s_item.frame_byte    = s_frame_byte;
    assign s_item.frame_length  = s_frame_length;
    assign s_item.is_management = s_is_management;
    assign s_item.last_byte     = s_last_byte;

    // held word moves on when the result register is free or being emptied
    assign advance = item_valid && (!m_valid || m_ready);

    rid_ie_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rid_ie_scan #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    rid_ie_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    // result word unpacking
    assign m_match_kind     = m_res.match_kind;
    assign m_source_address = m_res.source_address;
    assign m_oui_select     = m_res.oui_select;
    assign m_payload_offset = m_res.payload_offset;
    assign m_payload_length = m_res.payload_length;

endmodule

[sv/rid_ie_in_reg.sv]
// input word register with valid/ready handshake
module rid_ie_in_reg
    import rid_ie_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // free when empty or when the held word moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[sv/rid_ie_scan.sv]
// per-frame scan state: nan address match, source capture, element walk
module rid_ie_scan
    import rid_ie_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    input  item_t   item,
    input  logic    advance,
    output logic    res_valid,
    output result_t res
);

    localparam int unsigned PW = $clog2(MAX_FRAME_BYTES);
    localparam int unsigned CW = (PW > NEXT_W) ? PW : NEXT_W;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES - 1);

    logic [PW-1:0]     pos_reg,    pos_next;
    logic [NEXT_W-1:0] ne_reg,     ne_next;
    logic [NEXT_W-1:0] start_reg,  start_next;
    logic [BYTE_W-1:0] etype_reg,  etype_next;
    logic [BYTE_W-1:0] elen_reg,   elen_next;
    logic [1:0]        oui_reg,    oui_next;
    logic              nan_reg,    nan_next;
    logic              beacon_reg, beacon_next;
    logic              stop_reg,   stop_next;
    logic [ADDR_W-1:0] src_reg,    src_next;

    logic [CW-1:0]     p_w, flen_w, ne_w, rel, nan_idx;
    logic [NEXT_W-1:0] ne_sum, pay_off;
    logic [1:0]        oui_hit;
    logic              nan_hit;
    logic [BYTE_W-1:0] b;

    // next state and result
    always_comb begin
        pos_next    = pos_reg;
        ne_next     = ne_reg;
        start_next  = start_reg;
        etype_next  = etype_reg;
        elen_next   = elen_reg;
        oui_next    = oui_reg;
        nan_next    = nan_reg;
        beacon_next = beacon_reg;
        stop_next   = stop_reg;
        src_next    = src_reg;
        res_valid   = 1'b0;
        res         = '0;

        b       = item.frame_byte;
        p_w     = CW'(pos_reg);
        flen_w  = CW'(item.frame_length);
        ne_w    = CW'(ne_reg);
        rel     = p_w - CW'(start_reg);
        nan_idx = p_w - CW'(NAN_ADDR_FIRST);
        ne_sum  = ne_reg + NEXT_W'(b) + NEXT_W'(IE_HDR_LEN);
        pay_off = start_reg + NEXT_W'(PAYLOAD_SKIP);
        oui_hit = oui_reg;
        nan_hit = 1'b0;

        if (item_valid && (p_w < flen_w)) begin
            // frame header
            if (pos_reg == '0) begin
                beacon_next = (b == BEACON_CODE);
            end
            if (p_w >= CW'(NAN_ADDR_FIRST) && p_w <= CW'(NAN_ADDR_LAST)
                && b != nan_cluster_byte(nan_idx[2:0])) begin
                nan_next = 1'b0;
            end
            if (p_w >= CW'(SRC_FIRST) && p_w <= CW'(SRC_LAST)) begin
                src_next = {src_reg[ADDR_W-BYTE_W-1:0], b};
            end
            nan_hit = nan_next && (item.frame_length >= FLEN_W'(NAN_MIN_LEN));

            // nan candidate once the source address is complete
            if (p_w == CW'(SRC_LAST) && nan_hit && item.is_management) begin
                res_valid          = 1'b1;
                res.match_kind     = KIND_NAN;
                res.source_address = src_next;
                res.oui_select     = 1'b0;
                res.payload_offset = '0;
                res.payload_length = item.frame_length;
            end

            // information element walk
            if (beacon_reg && !nan_hit && !stop_reg && p_w >= CW'(IE_START)) begin
                if (p_w == ne_w) begin
                    etype_next = b;
                    if (ne_w + CW'(1) >= flen_w) begin
                        stop_next = 1'b1;
                    end
                end else if (p_w == ne_w + CW'(1)) begin
                    elen_next  = b;
                    start_next = ne_reg;
                    if (CW'(ne_sum) > flen_w) begin
                        stop_next = 1'b1;
                    end else begin
                        ne_next = ne_sum;
                    end
                end else if (p_w < ne_w && etype_reg == VENDOR_IE
                             && elen_reg >= BYTE_W'(VENDOR_MIN_LEN)) begin
                    case (rel)
                        CW'(OUI_REL_0): begin
                            oui_next = {b == OUI_B_0, b == OUI_A_0};
                        end
                        CW'(OUI_REL_1): begin
                            oui_next = oui_reg & {b == OUI_B_1, b == OUI_A_1};
                        end
                        CW'(OUI_REL_2): begin
                            oui_hit  = oui_reg & {b == OUI_B_2, b == OUI_A_2};
                            oui_next = oui_hit;
                            if ((|oui_hit) && CW'(pay_off) < flen_w
                                && item.is_management) begin
                                res_valid          = 1'b1;
                                res.match_kind     = KIND_BEACON;
                                res.source_address = src_reg;
                                res.oui_select     = !oui_hit[0];
                                res.payload_offset = pay_off[FLEN_W-1:0];
                                res.payload_length = item.frame_length
                                                     - pay_off[FLEN_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        // frame end or byte count
        if (item.last_byte) begin
            pos_next    = '0;
            ne_next     = NEXT_W'(IE_START);
            start_next  = '0;
            etype_next  = '0;
            elen_next   = '0;
            oui_next    = '0;
            nan_next    = 1'b1;
            beacon_next = 1'b0;
            stop_next   = 1'b0;
            src_next    = '0;
        end else if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + PW'(1);
        end
    end

    // state registers, stepped once per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            ne_reg     <= NEXT_W'(IE_START);
            start_reg  <= '0;
            etype_reg  <= '0;
            elen_reg   <= '0;
            oui_reg    <= '0;
            nan_reg    <= 1'b1;
            beacon_reg <= 1'b0;
            stop_reg   <= 1'b0;
            src_reg    <= '0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            ne_reg     <= ne_next;
            start_reg  <= start_next;
            etype_reg  <= etype_next;
            elen_reg   <= elen_next;
            oui_reg    <= oui_next;
            nan_reg    <= nan_next;
            beacon_reg <= beacon_next;
            stop_reg   <= stop_next;
            src_reg    <= src_next;
        end
    end

endmodule

[sv/rid_ie_out_reg.sv]
// result word register toward the output channel
module rid_ie_out_reg
    import rid_ie_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  logic    res_valid,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    // valid flag: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

[tb/remote_id_frame_ie_filter_checker.sv]
// match predictor and result checker for the remote id frame element filter
module remote_id_frame_ie_filter_checker
    import rid_ie_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BYTE_W-1:0] s_frame_byte,
    input  logic [FLEN_W-1:0] s_frame_length,
    input  logic              s_is_management,
    input  logic              s_last_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_match_kind,
    input  logic [ADDR_W-1:0] m_source_address,
    input  logic              m_oui_select,
    input  logic [FLEN_W-1:0] m_payload_offset,
    input  logic [FLEN_W-1:0] m_payload_length,
    output int unsigned       mismatch_count,
    output int unsigned       matches_due,
    output int unsigned       nan_matches,
    output int unsigned       rid_matches
);

    localparam logic [ADDR_W-1:0] NAN_CLUSTER_ADDR = 48'h51_6f_9a_01_00_00;
    localparam logic OUI_SEL_A = 1'b0;
    localparam logic OUI_SEL_B = 1'b1;

    // scan state of the frame in flight
    int unsigned       byte_pos;
    int unsigned       next_ie;
    logic [BYTE_W-1:0] ie_type;
    logic [BYTE_W-1:0] ie_len;
    logic [1:0]        oui_live;
    bit                nan_addr_ok;
    bit                beacon_seen;
    bit                walk_done;
    logic [ADDR_W-1:0] src_addr;

    // matches predicted but not yet seen on the m_ side
    result_t     due_q[$];
    int unsigned err_count = 0;
    int unsigned nan_count = 0;
    int unsigned rid_count = 0;

    task automatic restart_frame();
        byte_pos    = 0;
        next_ie     = IE_START;
        ie_type     = '0;
        ie_len      = '0;
        oui_live    = '0;
        nan_addr_ok = 1'b1;
        beacon_seen = 1'b0;
        walk_done   = 1'b0;
        src_addr    = '0;
    endtask

    // one frame word through the address compare and the element walk
    task automatic scan_frame_word(input item_t w, output bit hit, output result_t r);
        int unsigned p;
        int unsigned flen;
        int unsigned b;
        int unsigned ne;
        int unsigned start;
        int unsigned pay_off;
        bit          nan_hit;
        p    = byte_pos;
        flen = w.frame_length;
        b    = w.frame_byte;
        hit  = 1'b0;
        r    = '0;
        if (p < flen) begin
            if (p == 0)
                beacon_seen = (b == BEACON_CODE);
            if (p >= NAN_ADDR_FIRST && p <= NAN_ADDR_LAST
                && b != NAN_CLUSTER_ADDR[ADDR_W-1-8*(p-NAN_ADDR_FIRST) -: 8])
                nan_addr_ok = 1'b0;
            if (p >= SRC_FIRST && p <= SRC_LAST)
                src_addr = {src_addr[ADDR_W-9:0], w.frame_byte};
            nan_hit = nan_addr_ok && flen >= NAN_MIN_LEN;

            // nan candidate once the source address is complete
            if (p == SRC_LAST && nan_hit && w.is_management) begin
                hit              = 1'b1;
                r.match_kind     = KIND_NAN;
                r.source_address = src_addr;
                r.oui_select     = OUI_SEL_A;
                r.payload_offset = '0;
                r.payload_length = w.frame_length;
            end

            // element walk over beacon bodies
            if (beacon_seen && !nan_hit && !walk_done && p >= IE_START) begin
                ne = next_ie;
                if (p == ne) begin
                    ie_type = w.frame_byte;
                    if (ne + 1 >= flen)
                        walk_done = 1'b1;
                end else if (p == ne + 1) begin
                    ie_len = w.frame_byte;
                    if (ne + b + IE_HDR_LEN > flen)
                        walk_done = 1'b1;
                    else
                        next_ie = ne + b + IE_HDR_LEN;
                end else if (p < ne && ne >= ie_len + IE_HDR_LEN) begin
                    start = ne - ie_len - IE_HDR_LEN;
                    if (p >= start && ie_type == VENDOR_IE && ie_len >= VENDOR_MIN_LEN) begin
                        case (p - start)
                            OUI_REL_0: begin
                                oui_live = {b == OUI_B_0, b == OUI_A_0};
                            end
                            OUI_REL_1: begin
                                if (b != OUI_A_1) oui_live[0] = 1'b0;
                                if (b != OUI_B_1) oui_live[1] = 1'b0;
                            end
                            OUI_REL_2: begin
                                if (b != OUI_A_2) oui_live[0] = 1'b0;
                                if (b != OUI_B_2) oui_live[1] = 1'b0;
                                pay_off = start + PAYLOAD_SKIP;
                                if (oui_live != 2'b00 && pay_off < flen
                                    && w.is_management) begin
                                    hit              = 1'b1;
                                    r.match_kind     = KIND_BEACON;
                                    r.source_address = src_addr;
                                    r.oui_select     = oui_live[0] ? OUI_SEL_A : OUI_SEL_B;
                                    r.payload_offset = FLEN_W'(pay_off);
                                    r.payload_length = FLEN_W'(flen - pay_off);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end

        if (w.last_byte)
            restart_frame();
        else if (byte_pos < MAX_FRAME_BYTES - 1)
            byte_pos++;
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // watch both channels at every edge
    always @(posedge aclk) begin : watch
        item_t   w;
        result_t want;
        result_t r;
        bit      hit;
        if (!aresetn) begin
            restart_frame();
            due_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    err_count++;
                    $display("%0t: match with none expected, kind %0d source %h offset %0d",
                             $time, m_match_kind, m_source_address, m_payload_offset);
                end else begin
                    want = due_q.pop_front();
                    check_field("match_kind", want.match_kind, m_match_kind);
                    check_field("source_address", want.source_address, m_source_address);
                    check_field("oui_select", want.oui_select, m_oui_select);
                    check_field("payload_offset", want.payload_offset, m_payload_offset);
                    check_field("payload_length", want.payload_length, m_payload_length);
                    if (want.match_kind == KIND_NAN)
                        nan_count++;
                    else
                        rid_count++;
                end
            end
            if (s_valid && s_ready) begin
                w.frame_byte    = s_frame_byte;
                w.frame_length  = s_frame_length;
                w.is_management = s_is_management;
                w.last_byte     = s_last_byte;
                scan_frame_word(w, hit, r);
                if (hit)
                    due_q.push_back(r);
            end
        end
        mismatch_count <= err_count;
        matches_due    <= due_q.size();
        nan_matches    <= nan_count;
        rid_matches    <= rid_count;
    end

endmodule

[tb/remote_id_frame_ie_filter_core_tb.sv]
// testbench top for the remote id frame element filter: frame stimulus and verdict
module remote_id_frame_ie_filter_core_tb;
    import rid_ie_pkg::*;

    localparam int unsigned WORD_TARGET      = 1200;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned MAX_FLEN         = 4095;
    localparam int unsigned RX_PHASE_CYCLES  = 250;

    typedef enum int {IE_PLAIN, IE_RID_A, IE_RID_B, IE_RID_BROKEN} ie_kind_e;
    typedef enum int {MGMT_SET, MGMT_CLEAR, MGMT_MIXED} mgmt_mode_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_frame_byte = '0;
    logic [FLEN_W-1:0] s_frame_length = '0;
    logic              s_is_management = 1'b0;
    logic              s_last_byte = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_match_kind;
    logic [ADDR_W-1:0] m_source_address;
    logic              m_oui_select;
    logic [FLEN_W-1:0] m_payload_offset;
    logic [FLEN_W-1:0] m_payload_length;

    int unsigned mismatch_count;
    int unsigned matches_due;
    int unsigned nan_matches;
    int unsigned rid_matches;

    remote_id_frame_ie_filter_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_byte     (s_frame_byte),
        .s_frame_length   (s_frame_length),
        .s_is_management  (s_is_management),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_kind     (m_match_kind),
        .m_source_address (m_source_address),
        .m_oui_select     (m_oui_select),
        .m_payload_offset (m_payload_offset),
        .m_payload_length (m_payload_length)
    );

    remote_id_frame_ie_filter_checker chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_byte     (s_frame_byte),
        .s_frame_length   (s_frame_length),
        .s_is_management  (s_is_management),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_kind     (m_match_kind),
        .m_source_address (m_source_address),
        .m_oui_select     (m_oui_select),
        .m_payload_offset (m_payload_offset),
        .m_payload_length (m_payload_length),
        .mismatch_count   (mismatch_count),
        .matches_due      (matches_due),
        .nan_matches      (nan_matches),
        .rid_matches      (rid_matches)
    );

    // 12 unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // cycle limit
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: run stopped at the cycle limit, %0d matches still due", matches_due);
        $display("tb: failure");
        $finish;
    end

    // receiver: rotating stall patterns plus a long hold on request
    int unsigned hold_requests = 0;
    int unsigned holds_done = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;
    rx_pattern_e rx_mode = RX_OPEN;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (rx_cycle % RX_PHASE_CYCLES == 0) begin
                    case ($urandom_range(0, 3))
                        0:       rx_mode = RX_OPEN;
                        1:       rx_mode = RX_COIN;
                        2:       rx_mode = RX_SPARSE;
                        default: rx_mode = RX_PERIODIC;
                    endcase
                end
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    // sender state
    logic [BYTE_W-1:0] frame_q[$];
    int unsigned       burst_left = 0;
    bit                no_gaps = 1'b0;
    int unsigned       words_sent = 0;
    int unsigned       frames_sent = 0;

    // offer one word, idling between bursts, and hold it until accepted
    task automatic offer_word(input item_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_frame_byte    <= w.frame_byte;
        s_frame_length  <= w.frame_length;
        s_is_management <= w.is_management;
        s_last_byte     <= w.last_byte;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_frame(input int unsigned flen, input mgmt_mode_e mode,
                              input bit flen_jitter);
        item_t       w;
        int unsigned i;
        for (i = 0; i < frame_q.size(); i++) begin
            w.frame_byte   = frame_q[i];
            w.frame_length = flen_jitter ? FLEN_W'($urandom_range(0, MAX_FLEN))
                                         : FLEN_W'(flen);
            case (mode)
                MGMT_SET:   w.is_management = 1'b1;
                MGMT_CLEAR: w.is_management = 1'b0;
                default:    w.is_management = 1'($urandom_range(0, 1));
            endcase
            w.last_byte = (i == frame_q.size() - 1);
            offer_word(w);
        end
        frames_sent++;
    endtask

    // frame start with random header bytes
    task automatic begin_frame(input logic [BYTE_W-1:0] first, input int unsigned n);
        frame_q.delete();
        frame_q.push_back(first);
        while (frame_q.size() < n)
            frame_q.push_back(8'($urandom));
    endtask

    task automatic put_nan_address();
        frame_q[4] = 8'h51;
        frame_q[5] = 8'h6f;
        frame_q[6] = 8'h9a;
        frame_q[7] = 8'h01;
        frame_q[8] = 8'h00;
        frame_q[9] = 8'h00;
    endtask

    // append one information element
    task automatic add_element(input ie_kind_e kind, input int unsigned len);
        logic [23:0] oui_a;
        logic [23:0] oui_b;
        logic [23:0] oui;
        int unsigned spoil;
        int unsigned i;
        oui_a = {OUI_A_0, OUI_A_1, OUI_A_2};
        oui_b = {OUI_B_0, OUI_B_1, OUI_B_2};
        case (kind)
            IE_RID_A: oui = oui_a;
            IE_RID_B: oui = oui_b;
            IE_RID_BROKEN: begin
                // one byte spoiled, either random or taken from the other oui
                spoil = $urandom_range(0, 2);
                if ($urandom_range(0, 1)) begin
                    oui = oui_a;
                    oui[23-8*spoil -: 8] = $urandom_range(0, 1) ? oui_b[23-8*spoil -: 8]
                                                                : 8'($urandom);
                end else begin
                    oui = oui_b;
                    oui[23-8*spoil -: 8] = $urandom_range(0, 1) ? oui_a[23-8*spoil -: 8]
                                                                : 8'($urandom);
                end
            end
            default: oui = 24'($urandom);
        endcase
        frame_q.push_back(kind == IE_PLAIN ? 8'($urandom) : VENDOR_IE);
        frame_q.push_back(8'(len));
        for (i = 0; i < len; i++)
            frame_q.push_back(i < 3 ? oui[23-8*i -: 8] : 8'($urandom));
    endtask

    // stop offering until every predicted match has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (matches_due != 0)
            @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned n;
        int unsigned i;
        int unsigned k;
        int unsigned flen;
        mgmt_mode_e  mode;
        ie_kind_e    kind;
        pick = $urandom_range(0, 99);
        n = $urandom_range(0, 99);
        mode = n < 85 ? MGMT_SET : (n < 90 ? MGMT_CLEAR : MGMT_MIXED);
        no_gaps = ($urandom_range(0, 4) == 0);
        if (pick < 20) begin
            // nan frames, some with a spoiled cluster address or odd length
            n = $urandom_range(10, 48);
            begin_frame(8'($urandom), n);
            if ($urandom_range(0, 3) != 0)
                put_nan_address();
            flen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_FLEN) : n;
            send_frame(flen, mode, 1'b0);
        end else if (pick < 85) begin
            // well-formed beacon element lists with random content
            begin_frame(BEACON_CODE, IE_START);
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                k = $urandom_range(0, 9);
                kind = k < 4 ? IE_RID_A
                             : (k < 7 ? IE_RID_B : (k < 8 ? IE_RID_BROKEN : IE_PLAIN));
                add_element(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                              : $urandom_range(3, 16));
            end
            k = $urandom_range(0, 99);
            if (k < 70) begin
                flen = frame_q.size();
            end else if (k < 80) begin
                flen = frame_q.size() - $urandom_range(1, 6);
            end else if (k < 88) begin
                flen = frame_q.size() + $urandom_range(1, MAX_FLEN - frame_q.size());
            end else begin
                // trailing bytes past the frame length
                flen = frame_q.size();
                repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
            end
            send_frame(flen, mode, 1'b0);
        end else begin
            // noise, sometimes with a length field that changes every word
            n = $urandom_range(1, 40);
            begin_frame($urandom_range(0, 1) ? BEACON_CODE : 8'($urandom), n);
            send_frame($urandom_range(0, MAX_FLEN), mode, 1'($urandom_range(0, 1)));
        end
    endtask

    // stimulus and verdict
    initial begin
        int unsigned i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // nan frames: minimum length, one short, management flag cleared
        begin_frame(8'h00, NAN_MIN_LEN);
        put_nan_address();
        send_frame(NAN_MIN_LEN, MGMT_SET, 1'b0);
        begin_frame(8'hff, NAN_MIN_LEN - 1);
        put_nan_address();
        send_frame(NAN_MIN_LEN - 1, MGMT_SET, 1'b0);
        begin_frame(8'hd0, 24);
        put_nan_address();
        send_frame(24, MGMT_CLEAR, 1'b0);

        // nan address inside a beacon header suppresses the walk
        begin_frame(BEACON_CODE, IE_START);
        put_nan_address();
        add_element(IE_RID_A, 6);
        send_frame(frame_q.size(), MGMT_SET, 1'b0);

        // every element kind, short vendor element and the widest element
        begin_frame(BEACON_CODE, IE_START);
        add_element(IE_RID_A, 8);
        add_element(IE_RID_B, 3);
        add_element(IE_RID_A, 2);
        add_element(IE_PLAIN, 0);
        add_element(IE_RID_BROKEN, 5);
        add_element(IE_RID_B, 255);
        send_frame(frame_q.size(), MGMT_SET, 1'b0);

        // vendor element closing the frame: payload start lies past the end
        begin_frame(BEACON_CODE, IE_START);
        add_element(IE_RID_B, 4);
        send_frame(frame_q.size(), MGMT_SET, 1'b0);
        begin_frame(BEACON_CODE, IE_START);
        add_element(IE_RID_A, 3);
        send_frame(frame_q.size(), MGMT_SET, 1'b0);

        // element overrunning the frame, with bytes sent past the length
        begin_frame(BEACON_CODE, IE_START);
        add_element(IE_RID_A, 10);
        send_frame(frame_q.size() - 3, MGMT_SET, 1'b0);

        // element length byte outside the frame
        begin_frame(BEACON_CODE, IE_START);
        add_element(IE_RID_A, 5);
        add_element(IE_RID_A, 5);
        send_frame(IE_START + 8, MGMT_SET, 1'b0);

        // header only, and a zero length field
        begin_frame(BEACON_CODE, IE_START);
        send_frame(IE_START, MGMT_SET, 1'b0);
        begin_frame(BEACON_CODE, 20);
        send_frame(0, MGMT_SET, 1'b0);

        // truncated capture under the largest length field
        begin_frame(BEACON_CODE, IE_START);
        add_element(IE_RID_A, 20);
        add_element(IE_RID_B, 6);
        send_frame(MAX_FLEN, MGMT_MIXED, 1'b0);
        wait_drained();

        // long receiver hold while words keep coming: the block fills and stalls
        hold_requests++;
        no_gaps = 1'b1;
        for (i = 0; i < 3; i++) begin
            begin_frame(BEACON_CODE, IE_START);
            repeat (8) add_element(IE_RID_A, 3);
            send_frame(frame_q.size(), MGMT_SET, 1'b0);
        end
        wait_drained();

        // random frames up to the word budget
        while (words_sent < WORD_TARGET) begin
            random_frame();
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("tb: %0d words in %0d frames, %0d nan and %0d remote id matches checked",
                 words_sent, frames_sent, nan_matches, rid_matches);
        $display("tb: covered short and overrun elements, truncated frames, %s",
                 "nan and beacon candidates and a long output stall");
        if (mismatch_count == 0 && matches_due == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
sv/rid_ie_pkg.sv
sv/rid_ie_in_reg.sv
sv/rid_ie_scan.sv
sv/rid_ie_out_reg.sv
sv/remote_id_frame_ie_filter_core.sv
tb/remote_id_frame_ie_filter_checker.sv
tb/remote_id_frame_ie_filter_core_tb.sv
